FILE: sv/mva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants for the matched value aggregator.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned MODE_W      = 4;

  localparam logic [VALUE_W-1:0] S64_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] S64_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [MODE_W-1:0] {
    MODE_G_INC     = 4'd0,
    MODE_G_LAST    = 4'd1,
    MODE_G_PERSIST = 4'd2,
    MODE_G_AVG     = 4'd3,
    MODE_G_MIN     = 4'd4,
    MODE_G_MAX     = 4'd5,
    MODE_G_ADD     = 4'd6,
    MODE_C_INC     = 4'd7,
    MODE_C_SET     = 4'd8,
    MODE_C_ADD     = 4'd9
  } mode_e;

endpackage

FILE: sv/matched_value_aggregator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matched_value_aggregator
// Folds parsed samples into a single accumulator, used as a gauge or counter by mode.
// ----------------------------------------------------------------------------
// Result: the result word is valid the cycle after accept; a running average
//   first runs 64 radix-2 restoring divider steps plus one final add.
// Flow: one word at a time; the next word is accepted the cycle after the
//   result is taken, so a stalled result also holds off the input.
// Reset: async active low; clears accumulator, count and flags, mode = g_last.
module matched_value_aggregator #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  action_i,
  input  logic signed [mva_pkg::VALUE_W-1:0]    sample_value_i,
  input  logic                                  sample_present_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  error_flag_o,
  output logic signed [mva_pkg::VALUE_W-1:0]    current_value_o,
  output logic [mva_pkg::OUT_COUNT_W-1:0]       current_count_o,
  output logic                                  value_is_undefined_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mva_pkg::MODE_W-1:0]            cfg_data_i
);

  localparam int unsigned VW     = mva_pkg::VALUE_W;
  localparam int unsigned DIV_W  = COUNT_BITS + 1;
  localparam int unsigned ITER_W = $clog2(VW);
  localparam logic [VW-1:0] ONE_FIXED = VW'(1) << FRAC_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [mva_pkg::MODE_W-1:0] mode_q;
  logic [VW-1:0]         acc_q, acc_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  hnv_q, hnv_d;
  logic                  err_q, err_d;

  logic [VW-1:0]         quo_q, quo_d;
  logic [DIV_W-1:0]      rem_q, rem_d;
  logic [DIV_W-1:0]      div_q, div_d;
  logic                  up_q, up_d;
  logic [ITER_W-1:0]     iter_q, iter_d;

  logic [VW-1:0]         v;
  logic [VW-1:0]         b_op;
  logic [VW-1:0]         sum;
  logic [VW-1:0]         sat_sum;
  logic                  ovf;
  logic                  v_lt_acc;
  logic                  acc_lt_v;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        trial_diff;
  logic                  trial_ge;
  logic [63:0]           cnt_ext;

  assign v = VW'(sample_value_i);

  // shared adder for increment and add modes
  always_comb begin
    if (mode_q == mva_pkg::MODE_G_INC) begin
      b_op = ONE_FIXED;
    end else if (mode_q == mva_pkg::MODE_C_INC) begin
      b_op = VW'(1);
    end else begin
      b_op = v;
    end
  end

  assign sum      = acc_q + b_op;
  assign ovf      = (acc_q[VW-1] == b_op[VW-1]) && (sum[VW-1] != acc_q[VW-1]);
  assign sat_sum  = ovf ? (acc_q[VW-1] ? mva_pkg::S64_MIN : mva_pkg::S64_MAX) : sum;
  assign v_lt_acc = $signed(v) < $signed(acc_q);
  assign acc_lt_v = $signed(acc_q) < $signed(v);
  assign cnt_inc  = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + COUNT_BITS'(1);

  // restoring divider step
  assign trial      = {rem_q, quo_q[VW-1]};
  assign trial_ge   = trial >= {1'b0, div_q};
  assign trial_diff = trial - {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    hnv_d   = hnv_q;
    err_d   = err_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    up_d    = up_q;
    iter_d  = iter_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_OUT;
          err_d   = 1'b0;
          if (action_i) begin
            if (!(mode_q > mva_pkg::MODE_G_ADD || mode_q == mva_pkg::MODE_G_PERSIST)) begin
              acc_d = '0;
              hnv_d = (mode_q != mva_pkg::MODE_G_INC);
              cnt_d = '0;
            end
          end else if (mode_q > mva_pkg::MODE_C_ADD) begin
            err_d = 1'b1;
          end else if (mode_q == mva_pkg::MODE_G_INC) begin
            acc_d = hnv_q ? ONE_FIXED : sat_sum;
            hnv_d = 1'b0;
            cnt_d = cnt_inc;
          end else if (mode_q == mva_pkg::MODE_C_INC) begin
            acc_d = sum;
            hnv_d = 1'b0;
            cnt_d = cnt_inc;
          end else if (!sample_present_i) begin
            err_d = 1'b1;
          end else if (mode_q inside {mva_pkg::MODE_C_SET, mva_pkg::MODE_C_ADD}) begin
            acc_d = (mode_q == mva_pkg::MODE_C_SET) ? v : sum;
            hnv_d = 1'b0;
            cnt_d = cnt_inc;
          end else if (cnt_q == '0 ||
                       mode_q inside {mva_pkg::MODE_G_LAST, mva_pkg::MODE_G_PERSIST}) begin
            acc_d = v;
            hnv_d = 1'b0;
            cnt_d = cnt_inc;
          end else if (hnv_q) begin
            cnt_d = cnt_inc;
          end else begin
            cnt_d = cnt_inc;
            case (mode_q)
              mva_pkg::MODE_G_AVG: begin
                // |v - old| / (n + 1), count advances after the final add
                cnt_d   = cnt_q;
                up_d    = acc_lt_v;
                quo_d   = acc_lt_v ? (v - acc_q) : (acc_q - v);
                rem_d   = '0;
                div_d   = {1'b0, cnt_q} + DIV_W'(1);
                iter_d  = ITER_W'(VW - 1);
                state_d = S_DIV;
              end
              mva_pkg::MODE_G_MIN: begin
                if (v_lt_acc) begin
                  acc_d = v;
                end
              end
              mva_pkg::MODE_G_MAX: begin
                if (acc_lt_v) begin
                  acc_d = v;
                end
              end
              default: begin
                acc_d = sat_sum;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        rem_d  = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quo_d  = {quo_q[VW-2:0], trial_ge};
        iter_d = iter_q - ITER_W'(1);
        if (iter_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        acc_d   = up_q ? acc_q + quo_q : acc_q - quo_q;
        cnt_d   = cnt_inc;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= mva_pkg::MODE_G_LAST;
      acc_q   <= '0;
      cnt_q   <= '0;
      hnv_q   <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hnv_q   <= hnv_d;
      err_q   <= err_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
    up_q   <= up_d;
    iter_q <= iter_d;
  end

  assign cnt_ext = 64'(cnt_q);

  assign cfg_ready_o          = 1'b1;
  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = (state_q == S_OUT);
  assign error_flag_o         = err_q;
  assign current_value_o      = hnv_q ? '0 : acc_q;
  assign current_count_o      = (|cnt_ext[63:32]) ? {mva_pkg::OUT_COUNT_W{1'b1}}
                                                  : cnt_ext[31:0];
  assign value_is_undefined_o = hnv_q;

endmodule

FILE: sv/mva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks for the matched value aggregator, bound to the top level.
// ----------------------------------------------------------------------------
module mva_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               error_flag_o,
  input logic signed [mva_pkg::VALUE_W-1:0] current_value_o,
  input logic                               value_is_undefined_o
);

  // one word in flight: no accept while a result is pending
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while result pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accept");

  a_undef_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_is_undefined_o) |-> (current_value_o == '0))
    else $error("undefined gauge shows nonzero value");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(current_value_o) && $stable(error_flag_o)))
    else $error("stalled result word changed");

endmodule

bind matched_value_aggregator mva_checker u_mva_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .error_flag_o         (error_flag_o),
  .current_value_o      (current_value_o),
  .value_is_undefined_o (value_is_undefined_o)
);
